FILE: hw/rtl/rfp_pkg.sv
// Shared constants, codes and types for the rangefinder frame parser.
// No dependencies; compiled first.
package rfp_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned MM_W       = 16;
   localparam int unsigned CM_W       = 13;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 4;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned POS_W      = 2;

   localparam logic [BYTE_W-1:0] FRAME_HEADER  = 8'h5C;
   localparam logic [BYTE_W-1:0] CHECKSUM_BASE = 8'h5B;
   localparam logic [POS_W-1:0]  POS_CHECKSUM  = 2'd3;

   // x / 10 == (x * 0xCCCD) >> 19, exact for every 16-bit x
   localparam logic [MM_W-1:0]   DIV10_RECIP   = 16'hCCCD;
   localparam int unsigned       DIV10_SHIFT   = 19;

   localparam logic [MM_W-1:0]   MIN_MM_RESET  = 16'd30;
   localparam logic [MM_W-1:0]   MAX_MM_RESET  = 16'd10000;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_DISTANCE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISTANCE = 4'd1;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_VALID        = 2'd0,
      STATUS_OUT_OF_RANGE = 2'd1,
      STATUS_NO_DATA      = 2'd2
   } status_type;

   // result of one processed item, core to top
   typedef struct packed {
      logic              emit;
      status_type        status;
      logic [CM_W-1:0]   distance_cm;
   } result_type;

endpackage

FILE: hw/rtl/rfp_ifs.sv
// Channel interfaces: request, response and register write.
// Depends on rfp_pkg.
interface rfp_req_if import rfp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, kind, rx_byte, input ready);
   modport sink   (input valid, kind, rx_byte, output ready);
endinterface

interface rfp_rsp_if import rfp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CM_W-1:0]     distance_cm;

   modport source (output valid, status, distance_cm, input ready);
   modport sink   (input valid, status, distance_cm, output ready);
endinterface

interface rfp_csr_if import rfp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rfp_parse_core.sv
// Frame assembly, checksum, range check and latest-result store.
// Depends on rfp_pkg.
module rfp_parse_core import rfp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              kind,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic [MM_W-1:0]   min_mm,
   input  logic [MM_W-1:0]   max_mm,
   output result_type        result
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] frame_ff [3];
   logic [CM_W-1:0]   dist_ff, dist_in;
   logic              oor_ff, oor_in;
   logic              flag_ff, flag_in;

   logic [BYTE_W-1:0]  sum;
   logic [BYTE_W-1:0]  expect_sum;
   logic [MM_W-1:0]    mm;
   logic [2*MM_W-1:0]  prod;
   logic               in_range;
   logic               store_byte;

   assign sum        = frame_ff[0] + frame_ff[1] + frame_ff[2];
   assign expect_sum = CHECKSUM_BASE - sum;
   assign mm         = {frame_ff[2], frame_ff[1]};
   assign prod       = mm * DIV10_RECIP;
   assign in_range   = (mm >= min_mm) && (mm <= max_mm);
   assign store_byte = step && (kind == KIND_BYTE) && (pos_ff != POS_CHECKSUM)
                       && !((pos_ff == '0) && (rx_byte != FRAME_HEADER));

   always_comb begin
      pos_in  = pos_ff;
      dist_in = dist_ff;
      oor_in  = oor_ff;
      flag_in = flag_ff;
      result  = '{emit: 1'b0, status: STATUS_NO_DATA, distance_cm: '0};
      if (step) begin
         if (kind == KIND_BYTE) begin
            if (store_byte) begin
               pos_in = pos_ff + 1'b1;
            end else if (pos_ff == POS_CHECKSUM) begin
               pos_in = '0;
               if (expect_sum == rx_byte) begin
                  flag_in = 1'b1;
                  oor_in  = !in_range;
                  dist_in = in_range ? prod[DIV10_SHIFT +: CM_W] : '0;
               end
            end
         end else begin
            result.emit = 1'b1;
            if (flag_ff) begin
               flag_in = 1'b0;
               if (oor_ff) begin
                  result.status = STATUS_OUT_OF_RANGE;
               end else begin
                  result.status      = STATUS_VALID;
                  result.distance_cm = dist_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         dist_ff <= '0;
         oor_ff  <= 1'b1;
         flag_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         dist_ff <= dist_in;
         oor_ff  <= oor_in;
         flag_ff <= flag_in;
      end
   end

   // frame bytes need no reset: each is written before the checksum reads it
   always_ff @(posedge clock) begin
      if (store_byte) begin
         frame_ff[pos_ff] <= rx_byte;
      end
   end

endmodule

FILE: hw/rtl/rangefinder_frame_parser.sv
// Top level of the rangefinder frame parser: input register, parse core,
// response register and the two bound registers. Depends on rfp_pkg,
// rfp_ifs and rfp_parse_core.
//
//   channel  dir  payload                      item
//   req_ch   in   kind, rx_byte                serial byte or read request
//   rsp_ch   out  status, distance_cm          one per read request
//   csr_ch   in   index, data                  bound register write
//
// One item per cycle sustained while no read waits on a stalled response. The
// core works on the item straight out of the input register, so a read's answer
// is registered in the response register when the core takes the read.
// Synchronous active-high reset: empty pipeline, hunting for a header, no new
// data, stored result out of range, bounds 30 and 10000 mm.
// A stalled response only holds back a read request behind it; bytes keep
// flowing into the core since they never produce a response. A read held in
// the input register keeps req_ch.ready low until the response slot frees.
module rangefinder_frame_parser import rfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rfp_req_if.sink    req_ch,
   rfp_rsp_if.source  rsp_ch,
   rfp_csr_if.sink    csr_ch
);

   // bound registers
   logic [MM_W-1:0] min_mm_ff, max_mm_ff;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_kind_ff;
   logic [BYTE_W-1:0] s1_byte_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [CM_W-1:0]     rsp_dist_ff;

   logic       req_fire;
   logic       s1_go;
   logic       rsp_free;
   result_type result;

   // the response slot is free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   // the held item moves on unless it is a read blocked by a waiting response
   assign s1_go    = s1_valid_ff && ((s1_kind_ff == KIND_BYTE) || rsp_free);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   rfp_parse_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_go),
      .kind    (s1_kind_ff),
      .rx_byte (s1_byte_ff),
      .min_mm  (min_mm_ff),
      .max_mm  (max_mm_ff),
      .result  (result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_mm_ff    <= MIN_MM_RESET;
         max_mm_ff    <= MAX_MM_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            // unknown indexes are dropped
            unique case (csr_ch.index)
               REG_MIN_DISTANCE: min_mm_ff <= csr_ch.data;
               REG_MAX_DISTANCE: max_mm_ff <= csr_ch.data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_ch.kind;
         s1_byte_ff <= req_ch.rx_byte;
      end
      if (result.emit) begin
         rsp_status_ff <= result.status;
         rsp_dist_ff   <= result.distance_cm;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.distance_cm = rsp_dist_ff;

endmodule
